// ----- sv/tun_pkg.sv -----
package tun_pkg;

    localparam int CW  = 32;   // coordinate width
    localparam int DW  = 33;   // edge vector component width
    localparam int PW  = 66;   // edge product width
    localparam int NW  = 67;   // cross product component width
    localparam int MW  = 65;   // cross product magnitude width
    localparam int HW  = 33;   // upper half of a magnitude
    localparam int LW  = 32;   // lower half of a magnitude
    localparam int QW  = 31;   // unit normal magnitude width
    localparam int SQW = 130;  // squared magnitude width
    localparam int SW  = 132;  // squared length width
    localparam int RW  = 200;  // root iteration word width
    localparam int TGT_SHIFT = 62;
    localparam int ROOT_STEPS = 31;

    typedef logic signed [RW-1:0] wide_t;

    // Control group that travels with one item through the root stages
    typedef struct packed {
        logic          valid;
        logic [2:0]    neg;
        logic          zero;
        logic [SW-1:0] s;
    } root_ctl_t;

    // Per component iteration state
    typedef struct packed {
        logic signed [RW-1:0] r;
        logic signed [RW-1:0] p;
        logic [QW-1:0]        q;
    } root_lane_t;

endpackage

// ----- sv/triangle_unit_normal_top.sv -----
// Unit face normal of one triangle per request.
// Stages: 3 cross product stages, 4 squaring stages, 31 root bit stages, 1 output register.
// Throughput: one triangle per cycle; the whole pipeline holds while a result waits.
// Reset: rst_n clears all valid bits asynchronously; data registers are not reset.
module triangle_unit_normal_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (32 bits each, lowest first)
    input  logic [287:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // normal_x, normal_y, normal_z (32 bits each, lowest first)
    output logic [95:0]  m_axis_tdata,
    // degenerate
    output logic [0:0]   m_axis_tuser
);

    logic                              en;
    logic                              x_valid;
    logic [2:0]                        x_neg;
    logic [2:0][tun_pkg::MW-1:0]       x_mag;
    tun_pkg::root_ctl_t                ctl  [tun_pkg::ROOT_STEPS+1];
    tun_pkg::root_lane_t               lane [tun_pkg::ROOT_STEPS+1][3];
    logic                              out_valid_reg;
    logic [95:0]                       out_data_reg;
    logic [95:0]                       out_data_next;
    logic                              out_degen_reg;
    tun_pkg::root_ctl_t                fin_ctl;

    // Hold every stage while a result waits untaken
    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    tun_cross u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .in_data   (s_axis_tdata),
        .out_valid (x_valid),
        .out_neg   (x_neg),
        .out_mag   (x_mag)
    );

    tun_square u_square (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (x_valid),
        .in_neg   (x_neg),
        .in_mag   (x_mag),
        .out_ctl  (ctl[0]),
        .out_lane (lane[0])
    );

    // One stage per result bit, highest bit first
    for (genvar i = 0; i < tun_pkg::ROOT_STEPS; i++)
    begin : g_root
        tun_root_stage #(
            .BIT (tun_pkg::ROOT_STEPS - 1 - i)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_ctl   (ctl[i]),
            .in_lane  (lane[i]),
            .out_ctl  (ctl[i+1]),
            .out_lane (lane[i+1])
        );
    end

    assign fin_ctl = ctl[tun_pkg::ROOT_STEPS];

    // Apply signs, zero a degenerate result
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            if (fin_ctl.zero)
                out_data_next[32*l +: 32] = '0;
            else if (fin_ctl.neg[l])
                out_data_next[32*l +: 32] = -{1'b0, lane[tun_pkg::ROOT_STEPS][l].q};
            else
                out_data_next[32*l +: 32] = {1'b0, lane[tun_pkg::ROOT_STEPS][l].q};
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= fin_ctl.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg  <= out_data_next;
            out_degen_reg <= fin_ctl.zero;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_degen_reg;

endmodule

// ----- sv/tun_cross.sv -----
module tun_cross (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic [9*tun_pkg::CW-1:0]              in_data,
    output logic                                  out_valid,
    output logic [2:0]                            out_neg,
    output logic [2:0][tun_pkg::MW-1:0]           out_mag
);

    logic                          v1_reg, v2_reg, v3_reg;
    logic signed [tun_pkg::DW-1:0] u_reg [3];
    logic signed [tun_pkg::DW-1:0] w_reg [3];
    logic signed [tun_pkg::PW-1:0] p_reg [6];
    logic [2:0]                    neg_reg;
    logic [2:0][tun_pkg::MW-1:0]   mag_reg;
    logic signed [tun_pkg::DW-1:0] u_next [3];
    logic signed [tun_pkg::DW-1:0] w_next [3];
    logic signed [tun_pkg::NW-1:0] n_next [3];
    logic [2:0]                    neg_next;
    logic [2:0][tun_pkg::MW-1:0]   mag_next;

    // Form the edge vectors b - a and c - a
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            u_next[i] = $signed({in_data[32*(i+3)+31], in_data[32*(i+3) +: 32]})
                      - $signed({in_data[32*i+31], in_data[32*i +: 32]});
            w_next[i] = $signed({in_data[32*(i+6)+31], in_data[32*(i+6) +: 32]})
                      - $signed({in_data[32*i+31], in_data[32*i +: 32]});
        end
    end

    // Subtract the product pairs and split sign from magnitude
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            n_next[i] = $signed({p_reg[2*i][tun_pkg::PW-1], p_reg[2*i]})
                      - $signed({p_reg[2*i+1][tun_pkg::PW-1], p_reg[2*i+1]});
            neg_next[i] = n_next[i][tun_pkg::NW-1];
            mag_next[i] = neg_next[i] ? tun_pkg::MW'(-n_next[i]) : tun_pkg::MW'(n_next[i]);
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Advance payload: edges, products, magnitudes
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                u_reg[i] <= u_next[i];
                w_reg[i] <= w_next[i];
            end
            p_reg[0] <= u_reg[1] * w_reg[2];
            p_reg[1] <= u_reg[2] * w_reg[1];
            p_reg[2] <= u_reg[2] * w_reg[0];
            p_reg[3] <= u_reg[0] * w_reg[2];
            p_reg[4] <= u_reg[0] * w_reg[1];
            p_reg[5] <= u_reg[1] * w_reg[0];
            neg_reg  <= neg_next;
            mag_reg  <= mag_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_neg   = neg_reg;
    assign out_mag   = mag_reg;

endmodule

// ----- sv/tun_square.sv -----
module tun_square (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic [2:0]                         in_neg,
    input  logic [2:0][tun_pkg::MW-1:0]        in_mag,
    output tun_pkg::root_ctl_t                 out_ctl,
    output tun_pkg::root_lane_t                out_lane [3]
);

    logic                          v4_reg, v5_reg, v6_reg, v7_reg;
    logic [2:0]                    n4_reg, n5_reg, n6_reg, n7_reg;
    logic [2*tun_pkg::HW-1:0]      hh_reg [3];
    logic [tun_pkg::HW+tun_pkg::LW-1:0] hl_reg [3];
    logic [2*tun_pkg::LW-1:0]      ll_reg [3];
    logic [tun_pkg::SQW-1:0]       sq_reg [3];
    logic [tun_pkg::SQW-1:0]       sq_next [3];
    logic [tun_pkg::SW-1:0]        s_reg, s7_reg;
    logic [tun_pkg::SW-1:0]        s_next;
    tun_pkg::wide_t                tgt_reg [3];
    tun_pkg::root_lane_t           lane_reg [3];
    tun_pkg::wide_t                s_wide;

    // Recombine the partial products of each square
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_next[i] = ({hh_reg[i], 64'b0})
                       + (tun_pkg::SQW'(hl_reg[i]) << 33)
                       + tun_pkg::SQW'(ll_reg[i]);
        end
        s_next = tun_pkg::SW'(sq_reg[0]) + tun_pkg::SW'(sq_reg[1]) + tun_pkg::SW'(sq_reg[2]);
        s_wide = $signed({{(tun_pkg::RW-tun_pkg::SW){1'b0}}, s_reg});
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= in_valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    // Advance payload: partial products, squares, length, root seed
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n4_reg <= in_neg;
            n5_reg <= n4_reg;
            n6_reg <= n5_reg;
            n7_reg <= n6_reg;
            for (int i = 0; i < 3; i++)
            begin
                hh_reg[i] <= in_mag[i][64:32] * in_mag[i][64:32];
                hl_reg[i] <= in_mag[i][64:32] * in_mag[i][31:0];
                ll_reg[i] <= in_mag[i][31:0] * in_mag[i][31:0];
                sq_reg[i] <= sq_next[i];
                tgt_reg[i] <= $signed({{(tun_pkg::RW-tun_pkg::SQW){1'b0}}, sq_reg[i]})
                              <<< tun_pkg::TGT_SHIFT;
                lane_reg[i].r <= tgt_reg[i] - s_wide;
                lane_reg[i].p <= -s_wide;
                lane_reg[i].q <= '0;
            end
            s_reg  <= s_next;
            s7_reg <= s_reg;
        end
    end

    assign out_ctl.valid = v7_reg;
    assign out_ctl.neg   = n7_reg;
    assign out_ctl.zero  = (s7_reg == '0);
    assign out_ctl.s     = s7_reg;
    assign out_lane      = lane_reg;

endmodule

// ----- sv/tun_root_stage.sv -----
module tun_root_stage #(
    parameter int BIT = 30
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  tun_pkg::root_ctl_t   in_ctl,
    input  tun_pkg::root_lane_t  in_lane [3],
    output tun_pkg::root_ctl_t   out_ctl,
    output tun_pkg::root_lane_t  out_lane [3]
);

    localparam int SH_P = BIT + 2;
    localparam int SH_S = 2 * BIT + 2;
    localparam int SH_U = BIT + 1;

    logic                valid_reg;
    tun_pkg::root_ctl_t  ctl_reg;
    tun_pkg::root_lane_t lane_reg  [3];
    tun_pkg::root_lane_t lane_next [3];
    tun_pkg::wide_t      s_wide;
    tun_pkg::wide_t      delta [3];
    tun_pkg::wide_t      diff  [3];

    // Try this bit: take it when the squared bound still fits the target
    always_comb
    begin
        s_wide = $signed({{(tun_pkg::RW-tun_pkg::SW){1'b0}}, in_ctl.s});
        for (int l = 0; l < 3; l++)
        begin
            delta[l] = ($signed(in_lane[l].p) <<< SH_P) + (s_wide <<< SH_S);
            diff[l]  = $signed(in_lane[l].r) - delta[l];
            lane_next[l] = in_lane[l];
            if (!diff[l][tun_pkg::RW-1])
            begin
                lane_next[l].r      = diff[l];
                lane_next[l].p      = $signed(in_lane[l].p) + (s_wide <<< SH_U);
                lane_next[l].q[BIT] = 1'b1;
            end
        end
    end

    // Advance valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_ctl.valid;
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg  <= in_ctl;
            lane_reg <= lane_next;
        end
    end

    always_comb
    begin
        out_ctl       = ctl_reg;
        out_ctl.valid = valid_reg;
    end
    assign out_lane = lane_reg;

endmodule
